[hdl/salc_pkg.sv]
// shared types and constants for the set-associative cache model
`default_nettype none
package salc_pkg;
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_WIDTH   = 32;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int WAY_W        = $clog2(MAX_WAYS);
  localparam int WAYCNT_W     = $clog2(MAX_WAYS + 1);
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int LINE_W       = 1 + ADDR_WIDTH + RANK_W;
  localparam int ROW_W        = LINE_W * MAX_WAYS;
  localparam int CNT_W        = 32;

  localparam logic [1:0] OP_IGNORE = 2'd0;
  localparam logic [1:0] OP_LOAD   = 2'd1;
  localparam logic [1:0] OP_STORE  = 2'd2;
  localparam logic [1:0] OP_MODIFY = 2'd3;

  localparam logic [1:0] REG_SET_BITS = 2'd0;
  localparam logic [1:0] REG_WAYS     = 2'd1;
  localparam logic [1:0] REG_BLOCK    = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_EVAL, ST_OUT
  } state_t;

  typedef struct packed {
    logic clr_step;   // write zero row at clear index
    logic load;       // capture input beat
    logic rd;         // read set row
    logic eval;       // compute and write back
    logic out_load;   // load output register
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic second;     // modify has a second access pending
  } sts_t;
endpackage
`default_nettype wire

[hdl/salc_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[hdl/salc_ctrl.sv]
// controller state machine of the cache model
`default_nettype none
module salc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          in_ignore,
  input  wire logic          out_free,
  input  wire salc_pkg::sts_t sts,
  output salc_pkg::cmd_t     cmd,
  output logic               in_ready
);
  import salc_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          cmd.load = 1'b1;
          if (!in_ignore) state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd = 1'b1;
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = sts.second ? ST_READ : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

[hdl/salc_dp.sv]
// datapath: set rows, lookup, lru update and totals
`default_nettype none
module salc_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire salc_pkg::cmd_t              cmd,
  output salc_pkg::sts_t                   sts,
  input  wire logic [1:0]                  in_op,
  input  wire logic [salc_pkg::ADDR_WIDTH-1:0] in_addr,
  input  wire logic [2:0]                  set_bits,
  input  wire logic [3:0]                  ways_in_use,
  input  wire logic [4:0]                  block_bits,
  output logic                             res_hit,
  output logic                             res_evict,
  output logic [salc_pkg::CNT_W-1:0]       res_hits,
  output logic [salc_pkg::CNT_W-1:0]       res_misses,
  output logic [salc_pkg::CNT_W-1:0]       res_evicts,
  output logic                             res_last
);
  import salc_pkg::*;

  logic [1:0]            op;
  logic [ADDR_WIDTH-1:0] addr;
  logic                  second;
  logic [SET_W-1:0]      clr_idx;
  logic [SET_W-1:0]      set_idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [ROW_W-1:0]      row, row_new;
  logic                  we;
  logic [SET_W-1:0]      waddr;
  logic [ROW_W-1:0]      wdata;
  logic                  hit, evict, hit_r, evict_r;
  logic [CNT_W-1:0]      hits, misses, evicts;
  logic [WAYCNT_W-1:0]   nw;
  logic [6:0]            sh_tag;
  logic [ADDR_WIDTH-1:0] shifted;

  // set index and tag from the captured address, and the clamped way count
  always_comb begin
    int unsigned sb;
    sb = (set_bits > 3'(MAX_SET_BITS)) ? MAX_SET_BITS : int'(set_bits);
    shifted = addr >> block_bits;
    set_idx = SET_W'(shifted & ((ADDR_WIDTH'(1) << sb) - 1'b1));
    sh_tag  = 7'(block_bits) + 7'(sb);
    tag = (sh_tag >= 7'(ADDR_WIDTH)) ? '0 : (addr >> sh_tag);
    nw = (ways_in_use == 4'd0) ? WAYCNT_W'(1) :
         (ways_in_use > 4'(MAX_WAYS)) ? WAYCNT_W'(MAX_WAYS) : WAYCNT_W'(ways_in_use);
  end

  always_comb begin
    we    = cmd.clr_step | cmd.eval;
    waddr = cmd.clr_step ? clr_idx : set_idx;
    wdata = cmd.clr_step ? '0 : row_new;
  end

  salc_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_rows (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(set_idx), .rdata(row)
  );

  // lookup and lru update over one row
  always_comb begin
    logic [MAX_WAYS-1:0] v, use_w;
    logic [RANK_W-1:0]   rk [MAX_WAYS];
    logic [RANK_W-1:0]   hr, br;
    logic [WAY_W:0]      hw, fw, vw, fill;
    row_new = row;
    hw = (WAY_W+1)'(MAX_WAYS);
    fw = (WAY_W+1)'(MAX_WAYS);
    vw = '0;
    br = '0;
    hr = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      v[w]  = row[w*LINE_W + LINE_W-1];
      rk[w] = row[w*LINE_W +: RANK_W];
      use_w[w] = (WAYCNT_W'(w) < nw);
    end
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (use_w[w]) begin
        if (v[w]) begin
          if (hw == (WAY_W+1)'(MAX_WAYS) &&
              row[w*LINE_W+RANK_W +: ADDR_WIDTH] == tag) begin
            hw = (WAY_W+1)'(w);
            hr = rk[w];
          end
        end else if (fw == (WAY_W+1)'(MAX_WAYS)) fw = (WAY_W+1)'(w);
        if (w == 0 || rk[w] > br) begin
          br = rk[w];
          vw = (WAY_W+1)'(w);
        end
      end
    end
    hit   = (hw != (WAY_W+1)'(MAX_WAYS));
    evict = !hit && (fw == (WAY_W+1)'(MAX_WAYS));
    fill  = hit ? hw : (evict ? vw : fw);
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (use_w[w] && v[w] && (WAY_W+1)'(w) != fill && (!hit || rk[w] < hr)) begin
        row_new[w*LINE_W +: RANK_W] = (rk[w] == RANK_W'(MAX_WAYS-1)) ? rk[w] : rk[w] + 1'b1;
      end
      if ((WAY_W+1)'(w) == fill) begin
        row_new[w*LINE_W +: LINE_W] = {1'b1, tag, {RANK_W{1'b0}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
      hits    <= '0;
      misses  <= '0;
      evicts  <= '0;
      second  <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_idx <= clr_idx + 1'b1;
      if (cmd.load) second <= (in_op == OP_MODIFY);
      if (cmd.out_load) second <= 1'b0;
      if (cmd.eval) begin
        if (hit) hits <= hits + 1'b1;
        else misses <= misses + 1'b1;
        if (evict) evicts <= evicts + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op   <= in_op;
      addr <= in_addr;
    end
    if (cmd.eval) begin
      hit_r   <= hit;
      evict_r <= evict;
    end
    if (cmd.out_load) begin
      res_hit    <= hit_r;
      res_evict  <= evict_r;
      res_hits   <= hits;
      res_misses <= misses;
      res_evicts <= evicts;
      res_last   <= !second;
    end
  end

  assign sts.clr_done = (clr_idx == SET_W'(NUM_SETS-1));
  assign sts.second   = second;

  // row read runs every cycle, so the read command is not needed here
  logic unused_op;
  assign unused_op = ^op ^ cmd.rd;
endmodule
`default_nettype wire

[hdl/set_assoc_lru_cache_model_unit.sv]
// top level of the set-associative lru cache model
// load or store: accept, read row, compare and write back, output; a modify does all but the
// accept twice; no new request is taken until the last result is loaded, which waits while
// the output register is full and not draining; reset: synchronous, and a clearing pass
// zeros all 64 set rows before input is taken; config writes apply to the next access; the
// user must make them only while no access is in flight, and the block does not enforce it
`default_nettype none
module set_assoc_lru_cache_model_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // operation[1:0], address[33:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [103:0]     m_axis_tdata,   // was_hit, was_eviction, hit_total,
                                           // miss_total, eviction_total
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);
  import salc_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_fire, out_free;
  logic [2:0] set_bits;
  logic [3:0] ways_in_use;
  logic [4:0] block_bits;
  logic r_hit, r_evict, r_last;
  logic [CNT_W-1:0] r_hits, r_misses, r_evicts;

  assign in_fire  = s_axis_tvalid & s_axis_tready;
  // output register free when empty or draining this cycle
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd4;
      ways_in_use <= 4'd1;
      block_bits  <= 5'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SET_BITS: set_bits    <= cfg_data[2:0];
        REG_WAYS:     ways_in_use <= cfg_data[3:0];
        REG_BLOCK:    block_bits  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  salc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_ignore(s_axis_tdata[1:0] == OP_IGNORE),
    .out_free(out_free), .sts(sts), .cmd(cmd), .in_ready(s_axis_tready)
  );

  salc_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_op(s_axis_tdata[1:0]), .in_addr(s_axis_tdata[33:2]),
    .set_bits(set_bits), .ways_in_use(ways_in_use), .block_bits(block_bits),
    .res_hit(r_hit), .res_evict(r_evict), .res_hits(r_hits),
    .res_misses(r_misses), .res_evicts(r_evicts), .res_last(r_last)
  );

  // output beat valid flag
  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (cmd.out_load) m_axis_tvalid <= 1'b1;
    else if (m_axis_tready) m_axis_tvalid <= 1'b0;
  end

  assign m_axis_tdata = {6'd0, r_evicts, r_misses, r_hits, r_evict, r_hit};
  assign m_axis_tlast = r_last;

  logic unused_in;
  assign unused_in = ^s_axis_tdata[39:34] ^ ^cfg_data[7:5];
endmodule
`default_nettype wire

[hdl/salc_check.sv]
// port-level checker for the cache model, bound to the top level
`default_nettype none
module salc_check (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [103:0] m_axis_tdata,
  input wire logic         m_axis_tlast,
  input wire logic         s_axis_tready
);
  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("valid dropped");
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1])) else $error("hit and evict");
  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready mid item");
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid) else $error("output after reset");
endmodule
bind set_assoc_lru_cache_model_unit salc_check u_check (.*);
`default_nettype wire

[sim/set_assoc_lru_cache_model_unit_tb.sv]
// self-checking testbench for the set-associative lru cache model unit
`default_nettype none
module set_assoc_lru_cache_model_unit_tb;
  import salc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_LEN    = 500;
  localparam int DRAIN_WAIT  = 12;
  localparam int NUM_LINES   = NUM_SETS * MAX_WAYS;
  localparam logic [1:0] REG_UNKNOWN = 2'd3;

  // one access request as offered on the input stream
  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
  } access_t;

  // one lookup outcome as seen on the output stream
  typedef struct {
    logic        hit;
    logic        evict;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
    logic        last;
  } lookup_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [39:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [7:0]   cfg_data = '0;

  set_assoc_lru_cache_model_unit dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predicted tag store and counters, mirroring the block's own state
  logic        line_vld [NUM_LINES];
  logic [31:0] line_tag [NUM_LINES];
  logic [2:0]  line_rank [NUM_LINES];
  logic [31:0] hit_cnt, miss_cnt, evict_cnt;
  logic [2:0]  set_bits_reg;
  logic [3:0]  ways_reg;
  logic [4:0]  block_reg;

  access_t access_q [$];     // requests waiting to be offered
  lookup_t lookup_q [$];     // outcomes still to arrive
  access_t cur_access;
  int      errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  logic    hold_go = 1'b0;
  logic    hold_done = 1'b0;
  int      hold_cnt = 0;
  int      quiet_cycles = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h (t=%0t)", what, got, want, $realtime);
    errors++;
  endtask

  // one tag lookup with lru update; returns the outcome it produces
  function automatic lookup_t cache_access(input logic [31:0] addr, input logic last);
    lookup_t     r;
    int          sb, nw, set, base, hit_way, free_way, fill, victim;
    logic [63:0] a;
    logic [63:0] tag;
    logic [2:0]  hr;
    sb = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : set_bits_reg;
    nw = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
    a = {32'b0, addr};
    set = int'((a >> block_reg) & ((64'd1 << sb) - 1));
    tag = a >> (block_reg + sb);
    base = set * MAX_WAYS;
    hit_way = -1;
    free_way = -1;
    r.evict = 1'b0;
    for (int w = 0; w < nw; w++) begin
      if (line_vld[base+w]) begin
        if (hit_way < 0 && {32'b0, line_tag[base+w]} == tag) hit_way = w;
      end else if (free_way < 0) begin
        free_way = w;
      end
    end
    r.hit = (hit_way >= 0);
    if (r.hit) begin
      hr = line_rank[base+hit_way];
      for (int w = 0; w < nw; w++)
        if (w != hit_way && line_vld[base+w] && line_rank[base+w] < hr)
          line_rank[base+w] = (line_rank[base+w] == 3'd7) ? 3'd7 : line_rank[base+w] + 3'd1;
      line_rank[base+hit_way] = '0;
      hit_cnt++;
    end else begin
      miss_cnt++;
      if (free_way >= 0) begin
        fill = free_way;
      end else begin
        // oldest rank wins, lowest way among ties
        victim = 0;
        for (int w = 1; w < nw; w++)
          if (line_rank[base+w] > line_rank[base+victim]) victim = w;
        fill = victim;
        r.evict = 1'b1;
        evict_cnt++;
      end
      for (int w = 0; w < nw; w++)
        if (w != fill && line_vld[base+w])
          line_rank[base+w] = (line_rank[base+w] == 3'd7) ? 3'd7 : line_rank[base+w] + 3'd1;
      line_vld[base+fill] = 1'b1;
      line_tag[base+fill] = tag[31:0];
      line_rank[base+fill] = '0;
    end
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evicts = evict_cnt;
    r.last = last;
    return r;
  endfunction

  // expected outcomes of one accepted request
  task automatic predict_access(input access_t acc);
    if (acc.op == OP_MODIFY) begin
      lookup_q.push_back(cache_access(acc.addr, 1'b0));
      lookup_q.push_back(cache_access(acc.addr, 1'b1));
    end else if (acc.op != OP_IGNORE) begin
      lookup_q.push_back(cache_access(acc.addr, 1'b1));
    end
  endtask

  // input driver: one request beat at a time from the pending queue
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) predict_access(cur_access);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (access_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_access = access_q.pop_front();
          s_axis_tdata <= {6'b0, cur_access.addr, cur_access.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // output monitor: random back-pressure, one long hold-off on request
  always @(posedge clk) begin
    lookup_t want;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (lookup_q.size() == 0) begin
          $display("unexpected result beat (t=%0t)", $realtime);
          errors++;
        end else begin
          want = lookup_q.pop_front();
          if (m_axis_tdata[0] !== want.hit)
            report_mismatch("was_hit", 32'(m_axis_tdata[0]), 32'(want.hit));
          if (m_axis_tdata[1] !== want.evict)
            report_mismatch("was_eviction", 32'(m_axis_tdata[1]), 32'(want.evict));
          if (m_axis_tdata[33:2] !== want.hits)
            report_mismatch("hit_total", m_axis_tdata[33:2], want.hits);
          if (m_axis_tdata[65:34] !== want.misses)
            report_mismatch("miss_total", m_axis_tdata[65:34], want.misses);
          if (m_axis_tdata[97:66] !== want.evicts)
            report_mismatch("eviction_total", m_axis_tdata[97:66], want.evicts);
          if (m_axis_tlast !== want.last)
            report_mismatch("tlast", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= HOLD_LEN;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("set_assoc_lru_cache_model_unit verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SET_BITS: set_bits_reg = val[2:0];
      REG_WAYS:     ways_reg = val[3:0];
      REG_BLOCK:    block_reg = val[4:0];
      default: ;
    endcase
  endtask

  // wait until every request has gone in and every outcome has come back
  task automatic drain();
    while (access_q.size() > 0 || s_axis_tvalid || lookup_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic push_access(input logic [1:0] op, input logic [31:0] addr);
    access_t acc;
    acc.op = op;
    acc.addr = addr;
    access_q.push_back(acc);
  endtask

  initial begin
    logic [31:0] pool [16];
    int          n_phases;
    int          nsets, nways, nblock;
    logic [1:0]  op;
    for (int i = 0; i < NUM_LINES; i++) begin
      line_vld[i] = 1'b0;
      line_tag[i] = '0;
      line_rank[i] = '0;
    end
    hit_cnt = '0;
    miss_cnt = '0;
    evict_cnt = '0;
    set_bits_reg = 3'd4;
    ways_reg = 4'd1;
    block_reg = 5'd4;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: reset geometry, one way per set
    push_access(OP_IGNORE, 32'h0000_0000);
    push_access(OP_LOAD,   32'h0000_0000);
    push_access(OP_LOAD,   32'h0000_000f);   // same block, hit
    push_access(OP_STORE,  32'hffff_ffff);
    push_access(OP_MODIFY, 32'h1234_5670);   // miss then hit
    push_access(OP_LOAD,   32'h0000_0100);   // conflicts with set 0, evicts
    push_access(OP_STORE,  32'h0000_0000);
    push_access(OP_IGNORE, 32'hffff_ffff);
    push_access(OP_MODIFY, 32'hffff_fff0);
    drain();

    // directed: 4 ways, lru order and victim choice in one set
    write_reg(REG_WAYS, 8'd4);
    write_reg(REG_SET_BITS, 8'd0);
    write_reg(REG_BLOCK, 8'd0);
    write_reg(REG_UNKNOWN, 8'hff);   // ignored index
    for (int i = 0; i < 4; i++) push_access(OP_LOAD, 32'h100 * i);
    push_access(OP_LOAD, 32'h000);
    push_access(OP_STORE, 32'h400);  // evicts the oldest
    push_access(OP_LOAD, 32'h100);
    push_access(OP_MODIFY, 32'h800);
    push_access(OP_LOAD, 32'h000);
    drain();

    // random phases, sweeping geometry and idle patterns
    n_phases = 12;
    for (int p = 0; p < n_phases; p++) begin
      case (p)
        0: begin nsets = 0; nways = 1; nblock = 0; end
        1: begin nsets = 6; nways = 8; nblock = 26; end
        2: begin nsets = 7; nways = 15; nblock = 31; end
        3: begin nsets = 2; nways = 0; nblock = 3; end
        4: begin nsets = 6; nways = 8; nblock = 0; end
        5: begin nsets = 0; nways = 8; nblock = 2; end
        default: begin
          nsets = $urandom_range(7);
          nways = $urandom_range(15);
          nblock = $urandom_range(31);
        end
      endcase
      write_reg(REG_SET_BITS, 8'(nsets));
      write_reg(REG_WAYS, 8'(nways));
      write_reg(REG_BLOCK, 8'(nblock));
      case (p % 4)
        0: begin send_idle_pct <= 0;  recv_idle_pct <= 0;  end
        1: begin send_idle_pct <= 65; recv_idle_pct <= 0;  end
        2: begin send_idle_pct <= 0;  recv_idle_pct <= 65; end
        default: begin send_idle_pct <= 24; recv_idle_pct <= 24; end
      endcase
      if (p == 4) hold_go <= 1'b1;   // fill the block while results are held off
      // a small working set gives hits, conflicts and evictions
      for (int i = 0; i < 16; i++) pool[i] = $urandom();
      for (int i = 0; i < 120; i++) begin
        op = 2'($urandom_range(3));
        if ($urandom_range(9) < 8)
          push_access(op, pool[$urandom_range(15)] ^ ($urandom() & 32'h0000_00ff));
        else
          push_access(op, $urandom());
      end
      drain();   // sender pauses here until every outcome is back
    end

    if (errors == 0) begin
      $display("set_assoc_lru_cache_model_unit verification clean");
    end else begin
      $display("set_assoc_lru_cache_model_unit verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
hdl/salc_pkg.sv
hdl/salc_ram.sv
hdl/salc_ctrl.sv
hdl/salc_dp.sv
hdl/set_assoc_lru_cache_model_unit.sv
hdl/salc_check.sv
sim/set_assoc_lru_cache_model_unit_tb.sv
